// ----- sv/int8_scaled_dot_product_logits_assert.svh -----
// Assertion macros for the int8 scaled dot product logits block.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef INT8_SCALED_DOT_PRODUCT_LOGITS_ASSERT_SVH
`define INT8_SCALED_DOT_PRODUCT_LOGITS_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ISDP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication; the consequent may be a short sequence.
`define ISDP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error(msg);
`else
`define ISDP_ASSERT_IMP(lbl, ante, cons, msg)
`define ISDP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/isdp_pkg.sv -----
// Shared types and constants of the int8 scaled dot product logits block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package isdp_pkg;

	localparam int LANES     = 4;
	localparam int ELEM_W    = 8;
	localparam int ACC_W     = 32;
	localparam int SCALE_W   = 32;
	localparam int ROW_W     = 20;
	localparam int LOGIT_W   = 59;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 32;

	localparam logic [SCALE_W-1:0] ACT_SCALE_RESET = 32'd16777216;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACT_SCALE = 1'b0,
		CFG_FIRST_ROW = 1'b1
	} cfg_idx_t;

	// Operand selection of the shared multiplier.
	typedef enum logic [1:0] {
		MUL_NONE   = 2'd0,
		MUL_SCALES = 2'd1,
		MUL_LOW    = 2'd2,
		MUL_HIGH   = 2'd3
	} mul_sel_t;

	typedef struct packed {
		logic     accum;
		logic     capture;
		mul_sel_t mul_sel;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		logic [LANES-1:0][ELEM_W-1:0] weight;
		logic [LANES-1:0][ELEM_W-1:0] act;
		logic [SCALE_W-1:0]           row_scale;
	} item_t;

endpackage

`default_nettype wire

// ----- sv/isdp_ifs.sv -----
// Stream interfaces of the int8 scaled dot product logits block.
// One carries input items, one carries logits; valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface isdp_in_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] weight_0;
	logic signed [7:0] weight_1;
	logic signed [7:0] weight_2;
	logic signed [7:0] weight_3;
	logic signed [7:0] act_0;
	logic signed [7:0] act_1;
	logic signed [7:0] act_2;
	logic signed [7:0] act_3;
	logic [31:0]       row_scale;
	logic              last_of_row;

	modport source (output valid, weight_0, weight_1, weight_2, weight_3,
		act_0, act_1, act_2, act_3, row_scale, last_of_row, input ready);
	modport sink (input valid, weight_0, weight_1, weight_2, weight_3,
		act_0, act_1, act_2, act_3, row_scale, last_of_row, output ready);
endinterface

interface isdp_out_if;
	logic               valid;
	logic               ready;
	logic signed [58:0] logit;
	logic [19:0]        row_index;

	modport source (output valid, logit, row_index, input ready);
	modport sink (input valid, logit, row_index, output ready);
endinterface

`default_nettype wire

// ----- sv/int8_scaled_dot_product_logits.sv -----
// Top level of the int8 scaled dot product logits block.
// Depends on isdp_pkg, isdp_ifs, isdp_ctrl, isdp_dp and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

// The block computes one logit per embedding row. Each input transfer carries four
// signed int8 weights, four signed int8 activations, a row scale and a last-of-row flag.
// The four lane products are added into a 32-bit wrapping accumulator in the cycle the
// transfer is taken, so items that are not last of row go in at one per clock. On the
// last item the row scale is captured and the block uses the
// shared 33x33 multiplier: row scale times activation scale, then the accumulator times
// the low and the high half of that 64-bit scale; a final add, shift by 32 and
// saturation then form a signed 59-bit logit with 16 fraction bits. in_ch.ready is low
// while these multiplier passes and the result load run, and for as long as a previous
// logit waits unaccepted in the output register when the new one is ready to load.
// The output register lets the next row stream in while a
// finished logit waits. row_index is first_row plus the number of logits emitted since
// reset, modulo 2^20. Register 0 is the activation scale (unsigned Q8.24, reset 1.0) and
// register 1 is first_row; write them only while no row result is pending.

`include "int8_scaled_dot_product_logits_assert.svh"

module int8_scaled_dot_product_logits (
	input  logic                           clk,
	input  logic                           arst_n,
	isdp_in_if.sink                        in_ch,
	isdp_out_if.source                     out_ch,
	input  logic                           cfg_we,
	input  logic [isdp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [isdp_pkg::CFG_W-1:0]     cfg_data
);

	isdp_pkg::cmd_t  cmd;
	isdp_pkg::item_t item;

	// Gather the lane fields into the datapath's item word.
	always_comb begin
		item.weight[0] = in_ch.weight_0;
		item.weight[1] = in_ch.weight_1;
		item.weight[2] = in_ch.weight_2;
		item.weight[3] = in_ch.weight_3;
		item.act[0]    = in_ch.act_0;
		item.act[1]    = in_ch.act_1;
		item.act[2]    = in_ch.act_2;
		item.act[3]    = in_ch.act_3;
		item.row_scale = in_ch.row_scale;
	end

	// The controller owns both handshakes and issues one command word per cycle.
	isdp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_last   (in_ch.last_of_row),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	// The datapath holds the accumulator, the configuration registers and the result.
	isdp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.logit     (out_ch.logit),
		.row_index (out_ch.row_index)
	);

	// Accumulation happens exactly on an input transfer.
	`ISDP_ASSERT_IMP(a_accum_on_transfer, (in_ch.valid && in_ch.ready), cmd.accum, "lane sum not accumulated on transfer")
	`ISDP_ASSERT_IMP(a_transfer_on_accum, cmd.accum, (in_ch.valid && in_ch.ready), "accumulation without a transfer")
	// After the last item of a row the input stays closed while the multiplier works.
	`ISDP_ASSERT_NXT(a_busy_after_last, (in_ch.valid && in_ch.ready && in_ch.last_of_row), (!in_ch.ready ##1 !in_ch.ready ##1 !in_ch.ready ##1 !in_ch.ready), "input reopened before the logit was formed")
	// A result is only loaded when the output register is free or being emptied.
	`ISDP_ASSERT_IMP(a_no_overwrite, (cmd.load_out && out_ch.valid), out_ch.ready, "pending logit overwritten")

endmodule

`default_nettype wire

// ----- sv/isdp_ctrl.sv -----
// Controller of the int8 scaled dot product logits block.
// Sequences accumulation, the three multiplier passes and the result load; uses isdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isdp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output isdp_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_ACC,
		ST_SCALE,
		ST_LOW,
		ST_HIGH,
		ST_LOAD
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_ACC);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = isdp_pkg::MUL_NONE;
		cmd.accum    = (state_q == ST_ACC) && in_valid;
		cmd.capture  = (state_q == ST_ACC) && in_valid && in_last;
		cmd.load_out = (state_q == ST_LOAD) && (!out_valid_q || out_ready);
		case (state_q)
			ST_SCALE: cmd.mul_sel = isdp_pkg::MUL_SCALES;
			ST_LOW:   cmd.mul_sel = isdp_pkg::MUL_LOW;
			ST_HIGH:  cmd.mul_sel = isdp_pkg::MUL_HIGH;
			default:  cmd.mul_sel = isdp_pkg::MUL_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_ACC: begin
					if (cmd.capture) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: state_q <= ST_LOW;
				ST_LOW:   state_q <= ST_HIGH;
				ST_HIGH:  state_q <= ST_LOAD;
				ST_LOAD: begin
					if (cmd.load_out) begin
						state_q <= ST_ACC;
					end
				end
				default: state_q <= ST_ACC;
			endcase

			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/isdp_dp.sv -----
// Datapath of the int8 scaled dot product logits block: lane products, accumulator,
// configuration registers, one shared 33x33 multiplier and the result register; uses isdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isdp_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  isdp_pkg::cmd_t                       cmd,
	input  isdp_pkg::item_t                      item,
	input  logic                                 cfg_we,
	input  logic [isdp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [isdp_pkg::CFG_W-1:0]           cfg_data,
	output logic signed [isdp_pkg::LOGIT_W-1:0]  logit,
	output logic [isdp_pkg::ROW_W-1:0]           row_index
);

	localparam logic signed [66:0] SAT_HI = 67'sd288230376151711743;
	localparam logic signed [66:0] SAT_LO = -67'sd288230376151711744;

	logic [isdp_pkg::ACC_W-1:0]          acc_q;
	logic [isdp_pkg::SCALE_W-1:0]        act_scale_q;
	logic [isdp_pkg::ROW_W-1:0]          first_row_q;
	logic [isdp_pkg::ROW_W-1:0]          rows_done_q;
	logic [isdp_pkg::SCALE_W-1:0]        rs_q;
	logic [63:0]                         p_q;
	logic [65:0]                         lo_q;
	logic [65:0]                         hi_q;
	logic signed [isdp_pkg::LOGIT_W-1:0] logit_q;
	logic [isdp_pkg::ROW_W-1:0]          row_index_q;

	logic signed [17:0] lane_sum;
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] mul_p;
	logic signed [66:0] fin_sum;
	logic signed [66:0] fin_sat;

	// Sum of the lane products; at most 4 * 2^14 in magnitude, so 18 bits.
	always_comb begin
		lane_sum = '0;
		for (int i = 0; i < isdp_pkg::LANES; i++) begin
			lane_sum = lane_sum + 18'($signed(item.weight[i]) * $signed(item.act[i]));
		end
	end

	always_comb begin
		case (cmd.mul_sel)
			isdp_pkg::MUL_SCALES: begin
				mul_a = {1'b0, rs_q};
				mul_b = {1'b0, act_scale_q};
			end
			isdp_pkg::MUL_LOW: begin
				mul_a = {acc_q[31], acc_q};
				mul_b = {1'b0, p_q[31:0]};
			end
			isdp_pkg::MUL_HIGH: begin
				mul_a = {acc_q[31], acc_q};
				mul_b = {1'b0, p_q[63:32]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// total * p >> 32 (floor) equals hi + (lo >>> 32).
	assign fin_sum = {hi_q[65], hi_q} + {{33{lo_q[65]}}, lo_q[65:32]};

	always_comb begin
		if (fin_sum > SAT_HI) begin
			fin_sat = SAT_HI;
		end else if (fin_sum < SAT_LO) begin
			fin_sat = SAT_LO;
		end else begin
			fin_sat = fin_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			act_scale_q <= isdp_pkg::ACT_SCALE_RESET;
			first_row_q <= '0;
			rows_done_q <= '0;
		end else begin
			if (cmd.load_out) begin
				acc_q       <= '0;
				rows_done_q <= rows_done_q + 1'b1;
			end else if (cmd.accum) begin
				acc_q <= acc_q + {{14{lane_sum[17]}}, lane_sum};
			end
			if (cfg_we) begin
				case (cfg_index)
					isdp_pkg::CFG_ACT_SCALE: act_scale_q <= cfg_data;
					isdp_pkg::CFG_FIRST_ROW: first_row_q <= cfg_data[isdp_pkg::ROW_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rs_q <= item.row_scale;
		end
		case (cmd.mul_sel)
			isdp_pkg::MUL_SCALES: p_q  <= mul_p[63:0];
			isdp_pkg::MUL_LOW:    lo_q <= mul_p;
			isdp_pkg::MUL_HIGH:   hi_q <= mul_p;
			default: ;
		endcase
		if (cmd.load_out) begin
			logit_q     <= fin_sat[isdp_pkg::LOGIT_W-1:0];
			row_index_q <= first_row_q + rows_done_q;
		end
	end

	assign logit     = logit_q;
	assign row_index = row_index_q;

endmodule

`default_nettype wire
